[hw/rtl/rpe_pkg.sv]
package rpe_pkg;

  localparam int unsigned ErrW   = 18;
  localparam int unsigned CamW   = 39;
  localparam int unsigned MulAW  = 39;
  localparam int unsigned MulBW  = 22;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned DivW   = 60;
  localparam int unsigned RadW   = 52;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned SumW   = 52;
  localparam int unsigned CntW   = 16;
  localparam int unsigned DiffW  = 20;

  localparam logic [ErrW-1:0] OutlierError = 18'd16000;
  localparam logic [ErrW-1:0] NoInlierRms  = 18'd160000;
  localparam logic [ErrW-1:0] ErrMax       = 18'd262143;

  localparam logic [2:0] RegRot0  = 3'd0;
  localparam logic [2:0] RegRot1  = 3'd1;
  localparam logic [2:0] RegRot2  = 3'd2;
  localparam logic [2:0] RegTrans = 3'd3;
  localparam logic [2:0] RegFocal = 3'd4;
  localparam logic [2:0] RegLimit = 3'd5;

  typedef logic signed [CamW-1:0] cam_t;

endpackage

[hw/rtl/rpe_div.sv]
module rpe_div #(
  parameter int unsigned W = 60
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, num_q, num_d, den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [W:0]    trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[W-1]};
    if (start_i) begin
      rem_d = '0;
      num_d = num_i;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
        num_d = {num_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        num_d = {num_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[hw/rtl/rpe_sqrt.sv]
module rpe_sqrt #(
  parameter int unsigned RAD_W = 52
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAD_W-1:0]     rad_i,
  output logic                 done_o,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int unsigned RW = RAD_W / 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [RAD_W-1:0] rad_q, rad_d;
  logic [RW+1:0]    rem_q, rem_d;
  logic [RW-1:0]    res_q, res_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [RW+3:0]    cur, trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    cur    = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, res_q, 2'b01};
    if (start_i) begin
      rad_d = rad_i;
      rem_d = '0;
      res_d = '0;
      cnt_d = CW'(RW);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d = (RW+2)'(cur - trial);
        res_d = {res_q[RW-2:0], 1'b1};
      end else begin
        rem_d = cur[RW+1:0];
        res_d = {res_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

[hw/rtl/reprojection_error_rms.sv]
// A point with zero depth skips the projection and the square root. The input stalls while a
// point is in work and while its result waits. The cost is set by the shared 60-bit restoring
// divider (two divisions per point with nonzero depth, plus one on the last point of a set with
// inliers) and the 26-step square root.
// Reset clears the running sums, the sequencer and the output valid, and loads the registers
// with the identity rotation, zero translation, f = 1000.0, limit = 10.0.
module reprojection_error_rms #(
  parameter int unsigned MAX_POINTS = 65535
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [20:0]        world_x_i,
  input  logic signed [20:0]        world_y_i,
  input  logic signed [20:0]        world_z_i,
  input  logic signed [19:0]        image_u_i,
  input  logic signed [19:0]        image_v_i,
  input  logic                      final_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rpe_pkg::ErrW-1:0]  point_error_o,
  output logic                      is_inlier_o,
  output logic                      set_done_o,
  output logic [rpe_pkg::ErrW-1:0]  rms_error_o,
  output logic [rpe_pkg::CntW-1:0]  inlier_total_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [5:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import rpe_pkg::*;

  localparam int unsigned CapVal = (MAX_POINTS < 65535) ? MAX_POINTS : 65535;
  localparam logic [CntW-1:0] Cap = CntW'(CapVal);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CAM   = 4'd1;
  localparam logic [3:0] ST_PMUL  = 4'd2;
  localparam logic [3:0] ST_PDIV  = 4'd3;
  localparam logic [3:0] ST_PWAIT = 4'd4;
  localparam logic [3:0] ST_SQ0   = 4'd5;
  localparam logic [3:0] ST_SQ1   = 4'd6;
  localparam logic [3:0] ST_SQ2   = 4'd7;
  localparam logic [3:0] ST_SWAIT = 4'd8;
  localparam logic [3:0] ST_GATE  = 4'd9;
  localparam logic [3:0] ST_ACC   = 4'd10;
  localparam logic [3:0] ST_RDIV  = 4'd11;
  localparam logic [3:0] ST_RWAIT = 4'd12;
  localparam logic [3:0] ST_RSQRT = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [47:0] rot0_q, rot1_q, rot2_q;
  logic [62:0] trans_q;
  logic [19:0] focal_q;
  logic [ErrW-1:0] limit_q;

  logic [3:0] state_q, state_d;

  logic signed [20:0] wx_q, wy_q, wz_q;
  logic signed [19:0] iu_q, iv_q;
  logic               fin_q;
  cam_t               acc_q [3];
  logic [1:0]         row_q, col_q, prow_q;
  logic               pv_q, axis_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DiffW-1:0] du_q, dv_q;
  logic [37:0]        ssq_q;
  logic [ErrW-1:0]    err_q, rms_q;
  logic               inl_q;
  logic [SumW-1:0]    sum_q;
  logic [CntW-1:0]    cnt_q;

  logic [ErrW-1:0]    o_err_q, o_rms_q;
  logic [CntW-1:0]    o_tot_q;
  logic               o_inl_q, o_done_q, out_valid_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic [47:0]             rot_row;
  logic [15:0]             rot_ent;
  logic signed [20:0]      w_ent;
  cam_t                    c_sel, c_mag, z_mag;

  logic            div_start, sq_start, div_done, sq_done;
  logic [DivW-1:0] div_num, div_den, div_quot;
  logic [RadW-1:0] sq_rad;
  logic [RootW-1:0] sq_root;

  logic [20:0]        q_sat;
  logic signed [21:0] proj;
  logic signed [22:0] diff;
  logic signed [DiffW-1:0] diff_cl;
  logic [ErrW-1:0]    e_sat, r_sat;
  logic [SumW:0]      sum_add;
  logic               accept, cfg_wr, out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !(out_valid_q && out_stall_i);
  assign pready   = 1'b1;

  always_comb begin
    unique case (paddr[5:3])
      RegRot0:  prdata = {16'd0, rot0_q};
      RegRot1:  prdata = {16'd0, rot1_q};
      RegRot2:  prdata = {16'd0, rot2_q};
      RegTrans: prdata = {1'b0, trans_q};
      RegFocal: prdata = {44'd0, focal_q};
      RegLimit: prdata = {46'd0, limit_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q  <= 48'h4000_0000_0000;
      rot1_q  <= 48'h0000_4000_0000;
      rot2_q  <= 48'h0000_0000_4000;
      trans_q <= '0;
      focal_q <= 20'd16000;
      limit_q <= 18'd160;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        RegRot0:  rot0_q  <= pwdata[47:0];
        RegRot1:  rot1_q  <= pwdata[47:0];
        RegRot2:  rot2_q  <= pwdata[47:0];
        RegTrans: trans_q <= pwdata[62:0];
        RegFocal: focal_q <= pwdata[19:0];
        RegLimit: limit_q <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (row_q)
      2'd0:    rot_row = rot0_q;
      2'd1:    rot_row = rot1_q;
      default: rot_row = rot2_q;
    endcase
    case (col_q)
      2'd0:    begin rot_ent = rot_row[47:32]; w_ent = wx_q; end
      2'd1:    begin rot_ent = rot_row[31:16]; w_ent = wy_q; end
      default: begin rot_ent = rot_row[15:0];  w_ent = wz_q; end
    endcase
    c_sel = axis_q ? acc_q[1] : acc_q[0];
    c_mag = c_sel[CamW-1] ? -c_sel : c_sel;
    z_mag = acc_q[2][CamW-1] ? -acc_q[2] : acc_q[2];

    q_sat   = (|div_quot[DivW-1:20]) ? 21'h10_0000 : div_quot[20:0];
    proj    = (c_sel[CamW-1] ^ acc_q[2][CamW-1]) ? -$signed({1'b0, q_sat})
                                                 : $signed({1'b0, q_sat});
    diff    = 23'(proj) - 23'(axis_q ? iv_q : iu_q);
    if (diff > 23'sd262144) begin
      diff_cl = 20'sd262144;
    end else if (diff < -23'sd262144) begin
      diff_cl = -20'sd262144;
    end else begin
      diff_cl = diff[DiffW-1:0];
    end
    e_sat   = (|sq_root[RootW-1:ErrW]) ? ErrMax : sq_root[ErrW-1:0];
    r_sat   = e_sat;
    sum_add = {1'b0, sum_q} + (SumW+1)'(prod_q[35:0]);
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    state_d   = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CAM;
        end
      end
      ST_CAM: begin
        mul_a = MulAW'($signed(rot_ent));
        mul_b = MulBW'(w_ent);
        if (row_q == 2'd3 && !pv_q) begin
          state_d = (acc_q[2] == '0) ? ST_ACC : ST_PMUL;
        end
      end
      ST_PMUL: begin
        mul_a   = c_mag;
        mul_b   = $signed({2'b00, focal_q});
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        div_start = 1'b1;
        div_num   = {prod_q[57:0], 1'b0} + DivW'(z_mag);
        div_den   = DivW'({z_mag, 1'b0});
        state_d   = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (div_done) begin
          state_d = axis_q ? ST_SQ0 : ST_PMUL;
        end
      end
      ST_SQ0: begin
        mul_a   = MulAW'(du_q);
        mul_b   = MulBW'(du_q);
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a   = MulAW'(dv_q);
        mul_b   = MulBW'(dv_q);
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        sq_start = 1'b1;
        sq_rad   = RadW'(ssq_q + 38'(prod_q[36:0]));
        state_d  = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (sq_done) begin
          state_d = ST_GATE;
        end
      end
      ST_GATE: begin
        mul_a   = MulAW'(err_q);
        mul_b   = MulBW'(err_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (fin_q && (cnt_q != '0 || inl_q)) begin
          state_d = ST_RDIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_RDIV: begin
        div_start = 1'b1;
        div_num   = DivW'(sum_q);
        div_den   = DivW'(cnt_q);
        state_d   = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (div_done) begin
          sq_start = 1'b1;
          sq_rad   = div_quot[RadW-1:0];
          state_d  = ST_RSQRT;
        end
      end
      ST_RSQRT: begin
        if (sq_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      wx_q     <= world_x_i;
      wy_q     <= world_y_i;
      wz_q     <= world_z_i;
      iu_q     <= image_u_i;
      iv_q     <= image_v_i;
      fin_q    <= final_point_i;
      acc_q[0] <= cam_t'($signed(trans_q[62:42])) <<< 14;
      acc_q[1] <= cam_t'($signed(trans_q[41:21])) <<< 14;
      acc_q[2] <= cam_t'($signed(trans_q[20:0])) <<< 14;
      row_q    <= 2'd0;
      col_q    <= 2'd0;
      pv_q     <= 1'b0;
      axis_q   <= 1'b0;
      inl_q    <= 1'b0;
      err_q    <= OutlierError;
    end
    if (state_q == ST_CAM) begin
      if (pv_q) begin
        acc_q[prow_q] <= acc_q[prow_q] + prod_q[CamW-1:0];
      end
      if (row_q != 2'd3) begin
        prow_q <= row_q;
        pv_q   <= 1'b1;
        if (col_q == 2'd2) begin
          col_q <= 2'd0;
          row_q <= row_q + 2'd1;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end else begin
        pv_q <= 1'b0;
      end
    end
    if (state_q == ST_PWAIT && div_done) begin
      if (axis_q) begin
        dv_q <= diff_cl;
      end else begin
        du_q <= diff_cl;
      end
      axis_q <= 1'b1;
    end
    if (state_q == ST_SQ1) begin
      ssq_q <= 38'(prod_q[36:0]);
    end
    if (state_q == ST_SWAIT && sq_done) begin
      if (e_sat < limit_q) begin
        inl_q <= 1'b1;
        err_q <= e_sat;
      end
    end
    if (state_q == ST_RSQRT && sq_done) begin
      rms_q <= r_sat;
    end
    if (state_q == ST_OUT && out_free) begin
      o_err_q  <= err_q;
      o_inl_q  <= inl_q;
      o_done_q <= fin_q;
      o_rms_q  <= fin_q ? ((cnt_q == '0) ? NoInlierRms : rms_q) : '0;
      o_tot_q  <= fin_q ? cnt_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC && inl_q) begin
        sum_q <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
        if (cnt_q < Cap) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        if (fin_q) begin
          sum_q <= '0;
          cnt_q <= '0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  rpe_div #(.W(DivW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  rpe_sqrt #(.RAD_W(RadW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign out_valid_o    = out_valid_q;
  assign point_error_o  = o_err_q;
  assign is_inlier_o    = o_inl_q;
  assign set_done_o     = o_done_q;
  assign rms_error_o    = o_rms_q;
  assign inlier_total_o = o_tot_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while a point is in work");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Cap)
    else $error("inlier count above its cap");

  a_inlier_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_inlier_o) |-> (point_error_o < limit_q))
    else $error("inlier error not below the limit");

  a_set_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !set_done_o) |-> (rms_error_o == '0 && inlier_total_o == '0))
    else $error("set fields nonzero outside the last point");

endmodule
